[sv/tfc_pkg.sv]
// Shared types, constants and sample arithmetic for the temporal flicker clamp.
package tfc_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 2;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   localparam csr_addr_type CSR_STRENGTH = csr_addr_type'(0);
   localparam csr_addr_type CSR_AGGRESSIVE = csr_addr_type'(1);

   localparam logic [1:0] STRENGTH_RESET = 2'd1;
   localparam sample_type SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam sample_type SAMPLE_ONE = sample_type'(1);

   typedef struct packed {
      logic [1:0] strength;
      logic       aggressive;
   } cfg_type;

   typedef struct packed {
      sample_type d1;
      sample_type d2;
   } bound_type;

   function automatic sample_type umin(input sample_type a, input sample_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic sample_type umax(input sample_type a, input sample_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic sample_type sample_gap(input sample_type a, input sample_type b);
      return umax(a, b) - umin(a, b);
   endfunction

   function automatic sample_type sat_sub(input sample_type a, input sample_type b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic sample_type sat_add(input sample_type a, input sample_type b);
      logic [SAMPLE_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[SAMPLE_BITS] ? SAMPLE_MAX : sum[SAMPLE_BITS-1:0];
   endfunction

   function automatic sample_type ravg(input sample_type a, input sample_type b);
      logic [SAMPLE_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b} + {{SAMPLE_BITS{1'b0}}, 1'b1};
      return sum[SAMPLE_BITS:1];
   endfunction

endpackage

[sv/tfc_bound.sv]
// Motion bound: least neighbor distance, plain or split by sign.
module tfc_bound (
   input  tfc_pkg::cfg_type    cfg,
   input  tfc_pkg::sample_type cur,
   input  tfc_pkg::sample_type prev_mid,
   input  tfc_pkg::sample_type next_mid,
   input  tfc_pkg::sample_type prev_far,
   input  tfc_pkg::sample_type next_far,
   output tfc_pkg::bound_type  bound
);
   import tfc_pkg::*;

   sample_type diff_pm, diff_nm, diff_pf, diff_nf;
   sample_type plain_d;
   bound_type  signed_b;

   function automatic bound_type fold(input bound_type b, input sample_type nb,
                                      input sample_type c);
      bound_type r;
      sample_type d;
      d = sample_gap(nb, c);
      if (nb >= c) begin
         r.d1 = umin(d, b.d1);
         r.d2 = '0;
      end else begin
         r.d1 = '0;
         r.d2 = umin(d, b.d2);
      end
      return r;
   endfunction

   always_comb begin
      diff_pm = sample_gap(prev_mid, cur);
      diff_nm = sample_gap(next_mid, cur);
      diff_pf = sample_gap(prev_far, cur);
      diff_nf = sample_gap(next_far, cur);

      plain_d = diff_pm;
      if (cfg.strength > 2'd1) begin
         plain_d = umin(plain_d, diff_nm);
      end
      if (cfg.strength > 2'd2) begin
         plain_d = umin(umin(plain_d, diff_pf), diff_nf);
      end

      if (prev_mid >= cur) begin
         signed_b.d1 = diff_pm;
         signed_b.d2 = '0;
      end else begin
         signed_b.d1 = '0;
         signed_b.d2 = diff_pm;
      end
      if (cfg.strength > 2'd1) begin
         signed_b = fold(signed_b, next_mid, cur);
      end
      if (cfg.strength > 2'd2) begin
         signed_b = fold(signed_b, prev_far, cur);
         signed_b = fold(signed_b, next_far, cur);
      end

      if (cfg.aggressive) begin
         bound = signed_b;
      end else begin
         bound.d1 = plain_d;
         bound.d2 = plain_d;
      end
   end

endmodule

[sv/tfc_clamp.sv]
// Temporal average clamped between the near-neighbor limits.
module tfc_clamp (
   input  tfc_pkg::bound_type  bound,
   input  tfc_pkg::sample_type cur,
   input  tfc_pkg::sample_type prev_near,
   input  tfc_pkg::sample_type next_near,
   output tfc_pkg::sample_type result
);
   import tfc_pkg::*;

   sample_type upper_lim, lower_lim, avg;

   always_comb begin
      upper_lim = umax(sat_sub(umin(prev_near, next_near), bound.d1), cur);
      lower_lim = umin(sat_add(umax(prev_near, next_near), bound.d2), cur);
      avg       = ravg(sat_sub(ravg(prev_near, next_near), SAMPLE_ONE), cur);
      result    = umin(umax(avg, lower_lim), upper_lim);
   end

endmodule

[sv/temporal_flicker_clamp_unit.sv]
// Top level of the temporal flicker clamp: registers, handshake and datapath.
//
// Usage: each req_ beat carries one co-located pixel from the current frame and
// from up to three previous and three next frames; each rsp_ beat returns one
// flicker-reduced pixel, in the same order.
// The csr_ channel writes strength (index 0) and aggressive (index 1); it is
// always ready and must be written only while no pixel is in flight.
// A pixel accepted on req_ is captured in the input register, then moves to
// the result register, which drives rsp_. Throughput: one pixel per clock
// while the receiver does not stall; the whole per-pixel function sits in one
// combinational stage between the two registers.
// When the receiver stalls, the result register holds and the input register
// fills; req_ready drops only when both are full and rsp_ready is low, and it
// rises again in the cycle the stall clears.
// Reset (synchronous, active high) empties both stages and sets strength to 1
// and aggressive to 0.
module temporal_flicker_clamp_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tfc_pkg::sample_type    req_cur_sample,
   input  tfc_pkg::sample_type    req_prev_near,
   input  tfc_pkg::sample_type    req_prev_mid,
   input  tfc_pkg::sample_type    req_prev_far,
   input  tfc_pkg::sample_type    req_next_near,
   input  tfc_pkg::sample_type    req_next_mid,
   input  tfc_pkg::sample_type    req_next_far,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tfc_pkg::sample_type    rsp_out_sample,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  tfc_pkg::csr_addr_type  csr_addr,
   input  tfc_pkg::csr_data_type  csr_wdata
);
   import tfc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type cur_ff, pn_ff, pm_ff, pf_ff, nn_ff, nm_ff, nf_ff;
   sample_type out_ff, out_in;
   bound_type  bound;
   logic       out_free, s1_move, req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_STRENGTH: begin
               cfg_in.strength = csr_wdata[1:0];
            end
            CSR_AGGRESSIVE: begin
               cfg_in.aggressive = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strength   <= STRENGTH_RESET;
         cfg_ff.aggressive <= 1'b0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cur_ff <= req_cur_sample;
         pn_ff  <= req_prev_near;
         pm_ff  <= req_prev_mid;
         pf_ff  <= req_prev_far;
         nn_ff  <= req_next_near;
         nm_ff  <= req_next_mid;
         nf_ff  <= req_next_far;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   tfc_bound u_bound (
      .cfg      (cfg_ff),
      .cur      (cur_ff),
      .prev_mid (pm_ff),
      .next_mid (nm_ff),
      .prev_far (pf_ff),
      .next_far (nf_ff),
      .bound    (bound)
   );

   tfc_clamp u_clamp (
      .bound     (bound),
      .cur       (cur_ff),
      .prev_near (pn_ff),
      .next_near (nn_ff),
      .result    (out_in)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = out_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input refused while a stage is free");

   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted beat not in input stage");

   a_move_lands: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff && out_ff == $past(out_in))
      else $error("result register missed a beat");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (out_in <= umax(cur_ff, umin(pn_ff, nn_ff)))
                      && (out_in >= umin(cur_ff, umax(pn_ff, nn_ff))))
      else $error("result outside clamp limits");
`endif

endmodule

[tb/tb_temporal_flicker_clamp_unit.sv]
// Self-checking testbench for temporal_flicker_clamp_unit: directed table, then random pixels.
module tb_temporal_flicker_clamp_unit;
   import tfc_pkg::*;

   localparam int SAMPLE_TOP = (1 << SAMPLE_BITS) - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_COUNT = 9;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int DIRECTED_COUNT = 22;

   typedef struct packed {
      sample_type cur_sample;
      sample_type prev_near;
      sample_type prev_mid;
      sample_type prev_far;
      sample_type next_near;
      sample_type next_mid;
      sample_type next_far;
   } pixel_type;

   typedef struct packed {
      logic [1:0] strength;
      logic       aggressive;
      sample_type cur_sample;
      sample_type prev_near;
      sample_type prev_mid;
      sample_type prev_far;
      sample_type next_near;
      sample_type next_mid;
      sample_type next_far;
      logic       pinned;
      sample_type pinned_out;
   } vector_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   sample_type   req_cur_sample = '0;
   sample_type   req_prev_near = '0;
   sample_type   req_prev_mid = '0;
   sample_type   req_prev_far = '0;
   sample_type   req_next_near = '0;
   sample_type   req_next_mid = '0;
   sample_type   req_next_far = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   sample_type   rsp_out_sample;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   csr_addr_type csr_addr = CSR_STRENGTH;
   csr_data_type csr_wdata = '0;

   cfg_type    mode_shadow;
   sample_type pending_out_samples [$];
   sample_type checker_want;
   int         mismatch_count = 0;
   int         send_idle_pct = 17;
   int         recv_idle_pct = 58;
   logic       hold_request = 1'b0;
   int         cycle_count = 0;

   logic [1:0] phase_strength [PHASE_COUNT] = '{0, 2, 3, 1, 3, 2, 0, 1, 3};
   logic       phase_aggressive [PHASE_COUNT] = '{0, 0, 0, 1, 1, 1, 1, 1, 0};

   // strength, aggressive, cur, pn, pm, pf, nn, nm, nf, pinned, pinned_out
   vector_type directed_rows [DIRECTED_COUNT] = '{
      '{1, 0,   0,   0,   0,   0,   0,   0,   0, 1,   0},
      '{1, 0, 255, 255, 255, 255, 255, 255, 255, 1, 255},
      '{1, 0, 255,   0,   0,   0,   0,   0,   0, 1, 255},
      '{1, 0,   0, 255, 255, 255, 255, 255, 255, 1,   0},
      '{1, 0, 100, 100, 100, 100, 100, 100, 100, 1, 100},
      '{1, 0, 200, 100, 100,   0, 100, 255, 255, 0,   0},
      '{1, 0,  50,  60,  55, 255,  40,   0,   0, 0,   0},
      '{0, 0, 200, 100, 100,   0, 100, 255, 255, 0,   0},
      '{0, 1, 200, 100, 100, 255, 100,   0, 170, 0,   0},
      '{2, 0, 128, 255,   0,   0, 255, 255,   0, 0,   0},
      '{2, 0,  10,   0,  20, 255,  30,   5, 255, 0,   0},
      '{3, 0, 128, 120, 130,   0, 125, 126, 255, 0,   0},
      '{3, 0,   0, 255, 255, 255, 255, 255, 255, 1,   0},
      '{1, 1, 100,  90, 120,   0, 110,   0,   0, 0,   0},
      '{1, 1, 100,  90,  80, 255, 110, 255, 255, 0,   0},
      '{2, 1, 100, 150, 120,   0, 160,  80,   0, 0,   0},
      '{2, 1, 100,  50,  80,   0,  60, 120,   0, 0,   0},
      '{3, 1, 100, 110, 120,  90, 105, 130,  95, 0,   0},
      '{3, 1, 255, 255,   0, 255,   0, 255,   0, 0,   0},
      '{3, 1,   0,   0,   0,   0,   0,   0,   0, 1,   0},
      '{3, 1, 128, 129, 127, 127, 129, 129, 127, 0,   0},
      '{0, 1,   0, 255, 255,   0, 255,   0, 255, 0,   0}
   };

   temporal_flicker_clamp_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cur_sample (req_cur_sample),
      .req_prev_near  (req_prev_near),
      .req_prev_mid   (req_prev_mid),
      .req_prev_far   (req_prev_far),
      .req_next_near  (req_next_near),
      .req_next_mid   (req_next_mid),
      .req_next_far   (req_next_far),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic sample_type clamp_predict(input pixel_type px, input cfg_type mode);
      int cur, pn, nn, k, gap, used, up_gap, dn_gap, near_lo, near_hi, hi_edge, lo_edge;
      int blend, y;
      int outer [4];
      cur = int'(px.cur_sample);
      pn = int'(px.prev_near);
      nn = int'(px.next_near);
      outer[0] = int'(px.prev_mid);
      outer[1] = int'(px.next_mid);
      outer[2] = int'(px.prev_far);
      outer[3] = int'(px.next_far);
      used = (mode.strength == 2'd3) ? 4 : (mode.strength == 2'd2) ? 2 : 1;
      up_gap = SAMPLE_TOP + 1;
      dn_gap = SAMPLE_TOP + 1;
      for (k = 0; k < used; k++) begin
         gap = (outer[k] >= cur) ? outer[k] - cur : cur - outer[k];
         if (!mode.aggressive) begin
            up_gap = (gap < up_gap) ? gap : up_gap;
            dn_gap = up_gap;
         end else if (outer[k] >= cur) begin
            up_gap = (gap < up_gap) ? gap : up_gap;
            dn_gap = 0;
         end else begin
            dn_gap = (gap < dn_gap) ? gap : dn_gap;
            up_gap = 0;
         end
      end
      near_lo = (pn < nn) ? pn : nn;
      near_hi = (pn > nn) ? pn : nn;
      hi_edge = (near_lo > up_gap) ? near_lo - up_gap : 0;
      hi_edge = (hi_edge > cur) ? hi_edge : cur;
      lo_edge = (near_hi + dn_gap > SAMPLE_TOP) ? SAMPLE_TOP : near_hi + dn_gap;
      lo_edge = (lo_edge < cur) ? lo_edge : cur;
      blend = (pn + nn + 1) >> 1;
      blend = (blend > 0) ? blend - 1 : 0;
      blend = (blend + cur + 1) >> 1;
      y = (blend < lo_edge) ? lo_edge : blend;
      y = (y > hi_edge) ? hi_edge : y;
      return sample_type'(y);
   endfunction

   function automatic sample_type near_sample(input sample_type base);
      int v;
      case ($urandom_range(0, 4))
         0: v = $urandom_range(0, SAMPLE_TOP);
         1: v = int'(base) + int'($urandom_range(0, 12)) - 6;
         2: v = int'(base);
         3: v = ($urandom_range(0, 1) == 1) ? SAMPLE_TOP : 0;
         default: v = int'(base) + int'($urandom_range(0, 40)) - 20;
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_TOP) v = SAMPLE_TOP;
      return sample_type'(v);
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.cur_sample = ($urandom_range(0, 9) == 0) ? near_sample('0)
                                                  : sample_type'($urandom_range(0, SAMPLE_TOP));
      px.prev_near = near_sample(px.cur_sample);
      px.prev_mid = near_sample(px.cur_sample);
      px.prev_far = near_sample(px.cur_sample);
      px.next_near = near_sample(px.cur_sample);
      px.next_mid = near_sample(px.cur_sample);
      px.next_far = near_sample(px.cur_sample);
      return px;
   endfunction

   task automatic push_pixel(input pixel_type px, input logic pinned, input sample_type pinned_out);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cur_sample <= px.cur_sample;
      req_prev_near <= px.prev_near;
      req_prev_mid <= px.prev_mid;
      req_prev_far <= px.prev_far;
      req_next_near <= px.next_near;
      req_next_mid <= px.next_mid;
      req_next_far <= px.next_far;
      // hold the beat until it is taken
      do @(posedge clock); while (!req_ready);
      pending_out_samples.push_back(pinned ? pinned_out : clamp_predict(px, mode_shadow));
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (pending_out_samples.size() != 0) @(posedge clock);
   endtask

   task automatic apply_mode(input logic [1:0] strength, input logic aggressive);
      csr_data_type data;
      csr_valid <= 1'b1;
      csr_addr <= CSR_STRENGTH;
      csr_wdata <= strength;
      do @(posedge clock); while (!csr_ready);
      mode_shadow.strength = strength;
      // upper data bit is don't-care for the aggressive flag
      data = {$urandom_range(0, 1) == 1, aggressive};
      csr_addr <= CSR_AGGRESSIVE;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      mode_shadow.aggressive = data[0];
      csr_valid <= 1'b0;
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out_samples.size() == 0) begin
            $error("out_sample: expected none, actual %0d", rsp_out_sample);
            mismatch_count++;
         end else begin
            checker_want = pending_out_samples.pop_front();
            if (rsp_out_sample !== checker_want) begin
               $error("out_sample: expected %0d, actual %0d", checker_want, rsp_out_sample);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_temporal_flicker_clamp_unit: FAIL");
      $finish;
   end

   initial begin
      vector_type row;
      pixel_type  px;
      int         phase, n;
      mode_shadow.strength = STRENGTH_RESET;
      mode_shadow.aggressive = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_COUNT; n++) begin
         row = directed_rows[n];
         if (row.strength != mode_shadow.strength || row.aggressive != mode_shadow.aggressive) begin
            drain_pixels();
            apply_mode(row.strength, row.aggressive);
         end
         px.cur_sample = row.cur_sample;
         px.prev_near = row.prev_near;
         px.prev_mid = row.prev_mid;
         px.prev_far = row.prev_far;
         px.next_near = row.next_near;
         px.next_mid = row.next_mid;
         px.next_far = row.next_far;
         push_pixel(px, row.pinned, row.pinned_out);
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_pixels();
         apply_mode(phase_strength[phase], phase_aggressive[phase]);
         if (phase < 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 58;
         end else if (phase < 6) begin
            send_idle_pct = 58;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 40) hold_request = 1'b1;
            if (phase == 4 && n == 80) drain_pixels();
            push_pixel(random_pixel(), 1'b0, '0);
         end
      end

      drain_pixels();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_temporal_flicker_clamp_unit: PASS");
      end else begin
         $display("tb_temporal_flicker_clamp_unit: FAIL");
      end
      $finish;
   end

endmodule

[temporal_flicker_clamp_unit.f]
sv/tfc_pkg.sv
sv/tfc_bound.sv
sv/tfc_clamp.sv
sv/temporal_flicker_clamp_unit.sv
tb/tb_temporal_flicker_clamp_unit.sv
